// File: rtl/core/positional_sequence_store_core_assert.svh
// assertion macros used by the checker file of the sequence store core
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef POSITIONAL_SEQUENCE_STORE_CORE_ASSERT_SVH
`define POSITIONAL_SEQUENCE_STORE_CORE_ASSERT_SVH

// plain property, disabled while reset is asserted
`define PSQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("psq assertion failed");

// same-cycle implication
`define PSQ_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psq implication failed");

// next-cycle implication
`define PSQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psq next-cycle implication failed");

`endif

// File: rtl/core/psq_pkg.sv
// shared types and constants of the positional sequence store core
// no dependencies; used by every module of the block
package psq_pkg;

  // storage geometry
  localparam int unsigned Capacity  = 64;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxW      = $clog2(Capacity);
  localparam int unsigned CntW      = $clog2(Capacity + 1);

  // fixed field widths of the transactions
  localparam int unsigned KindW   = 3;
  localparam int unsigned PosW    = 6;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;

  // operation codes
  typedef enum logic [KindW-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_INSERT     = 3'd4,
    KIND_REMOVE     = 3'd5,
    KIND_READ       = 3'd6
  } kind_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // input transaction
  typedef struct packed {
    logic [KindW-1:0]         kind;
    logic [PosW-1:0]          position;
    logic signed [ValueW-1:0] value;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic [CntW-1:0]          count;
    logic signed [ValueW-1:0] out_value;
  } out_item_t;

  // shift command from control to the cell row
  typedef struct packed {
    logic                 open_gap;
    logic                 close_gap;
    logic [IdxW-1:0]      at;
    logic [DataWidth-1:0] data;
  } shift_cmd_t;

endpackage

// File: rtl/core/psq_cells.sv
// row of storage cells that shift left or right around one index
// depends on psq_pkg for geometry and the shift command type
module psq_cells (
  input  logic                           clk_i,
  input  logic                           fire_i,
  input  psq_pkg::shift_cmd_t            cmd_i,
  output logic [psq_pkg::DataWidth-1:0]  rd_data_o
);

  logic [psq_pkg::DataWidth-1:0] cells_q [psq_pkg::Capacity];
  logic [psq_pkg::DataWidth-1:0] cells_d [psq_pkg::Capacity];

  // next value of each cell from its own neighbors
  for (genvar i = 0; i < psq_pkg::Capacity; i++) begin : g_cell
    logic above_at;
    logic at_here;
    logic [psq_pkg::DataWidth-1:0] left_val;
    logic [psq_pkg::DataWidth-1:0] right_val;

    assign above_at = psq_pkg::IdxW'(i) > cmd_i.at;
    assign at_here  = psq_pkg::IdxW'(i) == cmd_i.at;

    if (i == 0) begin : g_first
      assign left_val = cells_q[i];
    end else begin : g_left
      assign left_val = cells_q[i-1];
    end

    if (i == psq_pkg::Capacity - 1) begin : g_last
      assign right_val = cells_q[i];
    end else begin : g_right
      assign right_val = cells_q[i+1];
    end

    always_comb begin
      cells_d[i] = cells_q[i];
      if (cmd_i.open_gap) begin
        if (above_at) begin
          cells_d[i] = left_val;
        end else if (at_here) begin
          cells_d[i] = cmd_i.data;
        end
      end else if (cmd_i.close_gap) begin
        if (above_at || at_here) begin
          cells_d[i] = right_val;
        end
      end
    end

    // payload only, no reset
    always_ff @(posedge clk_i) begin
      if (fire_i && (cmd_i.open_gap || cmd_i.close_gap)) begin
        cells_q[i] <= cells_d[i];
      end
    end
  end

  // element removed or read
  assign rd_data_o = cells_q[cmd_i.at];

endmodule

// File: rtl/core/psq_ctrl.sv
// operation decode, status checks and element count register
// depends on psq_pkg for codes, transaction types and the shift command
module psq_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  psq_pkg::in_item_t              item_i,
  input  logic [psq_pkg::DataWidth-1:0]  rd_data_i,
  output psq_pkg::shift_cmd_t            cmd_o,
  output psq_pkg::out_item_t             result_o
);

  logic [psq_pkg::CntW-1:0] used_q, used_d;
  logic [psq_pkg::CntW-1:0] last_idx;
  logic                     full;
  logic                     empty;
  logic                     out_of_range;
  logic                     take;
  psq_pkg::status_e         status;

  assign full         = used_q == psq_pkg::CntW'(psq_pkg::Capacity);
  assign empty        = used_q == '0;
  assign out_of_range = psq_pkg::CntW'(item_i.position) >= used_q;
  assign last_idx     = used_q - 1'b1;

  // decode and checks
  always_comb begin
    status         = psq_pkg::ST_OK;
    used_d         = used_q;
    take           = 1'b0;
    cmd_o.open_gap  = 1'b0;
    cmd_o.close_gap = 1'b0;
    cmd_o.at        = '0;
    cmd_o.data      = item_i.value[psq_pkg::DataWidth-1:0];
    unique case (psq_pkg::kind_e'(item_i.kind))
      psq_pkg::KIND_PUSH_FRONT,
      psq_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          status = psq_pkg::ST_FULL;
        end else begin
          cmd_o.open_gap = 1'b1;
          cmd_o.at = (psq_pkg::kind_e'(item_i.kind) == psq_pkg::KIND_PUSH_FRONT) ?
                     '0 : used_q[psq_pkg::IdxW-1:0];
          used_d = used_q + 1'b1;
        end
      end
      psq_pkg::KIND_POP_FRONT,
      psq_pkg::KIND_POP_BACK: begin
        if (empty) begin
          status = psq_pkg::ST_EMPTY;
        end else begin
          cmd_o.close_gap = 1'b1;
          cmd_o.at = (psq_pkg::kind_e'(item_i.kind) == psq_pkg::KIND_POP_FRONT) ?
                     '0 : last_idx[psq_pkg::IdxW-1:0];
          take   = 1'b1;
          used_d = last_idx;
        end
      end
      psq_pkg::KIND_INSERT: begin
        if (full) begin
          status = psq_pkg::ST_FULL;
        end else if (out_of_range) begin
          status = psq_pkg::ST_RANGE;
        end else begin
          cmd_o.open_gap = 1'b1;
          cmd_o.at       = psq_pkg::IdxW'(item_i.position);
          used_d         = used_q + 1'b1;
        end
      end
      psq_pkg::KIND_REMOVE,
      psq_pkg::KIND_READ: begin
        cmd_o.at = psq_pkg::IdxW'(item_i.position);
        if (empty) begin
          status = psq_pkg::ST_EMPTY;
        end else if (out_of_range) begin
          status = psq_pkg::ST_RANGE;
        end else begin
          take = 1'b1;
          if (psq_pkg::kind_e'(item_i.kind) == psq_pkg::KIND_REMOVE) begin
            cmd_o.close_gap = 1'b1;
            used_d          = last_idx;
          end
        end
      end
      default: begin
        // unused code: no operation
      end
    endcase
  end

  // result fields, removed or read word sign extended
  always_comb begin
    result_o.status    = status;
    result_o.count     = used_d;
    result_o.out_value = take ? psq_pkg::ValueW'($signed(rd_data_i)) : '0;
  end

  // element count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (fire_i) begin
      used_q <= used_d;
    end
  end

endmodule

// File: rtl/core/positional_sequence_store_core.sv
// Positional sequence store core: a bounded ordered list of up to 64 signed
// 32-bit words with push/pop at both ends, insert before, remove at and read
// at a position.
//
// Channels: in_valid_i/in_ready_o carry one operation (kind, position,
// value); out_valid_o/out_ready_i carry one result (status, count,
// out_value) per operation, in order. A transaction moves at a rising edge
// with valid and ready both high.
// Timing: an accepted operation is decoded from the input register and its
// result is registered in the result register once the result slot is free,
// shown on the output ports from then on.
// Throughput: one operation per cycle while results are taken. The register
// cells of the element row all shift at once, so no operation takes longer.
// Reset: the element count clears to zero and both stages go empty; stored
// words are not cleared and are never read before written.
// Stall: while a result waits, the input register holds its operation; a
// new operation is still taken into an empty input register, after which
// in_ready_o follows out_ready_i.
// depends on psq_pkg, psq_ctrl and psq_cells
module positional_sequence_store_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psq_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psq_pkg::out_item_t  out_item_o
);

  psq_pkg::in_item_t             in_q;
  logic                          in_valid_q;
  psq_pkg::out_item_t            out_q;
  logic                          out_valid_q;
  logic                          fire;
  psq_pkg::shift_cmd_t           cmd;
  psq_pkg::out_item_t            result;
  logic [psq_pkg::DataWidth-1:0] rd_data;

  // operation executes when its result slot is free
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  psq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (in_q),
    .rd_data_i (rd_data),
    .cmd_o     (cmd),
    .result_o  (result)
  );

  psq_cells u_cells (
    .clk_i     (clk_i),
    .fire_i    (fire),
    .cmd_i     (cmd),
    .rd_data_o (rd_data)
  );

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  // result stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: rtl/core/psq_checker.sv
// port-level checks of the positional sequence store core, bound to the top
// depends on psq_pkg and positional_sequence_store_core_assert.svh
`include "positional_sequence_store_core_assert.svh"

module psq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input psq_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input psq_pkg::out_item_t out_item_o
);

  logic in_fire;
  logic rpt_full;
  logic rpt_empty;
  logic at_cap;
  logic out_zero;

  assign in_fire   = in_valid_i && in_ready_o && rst_ni;
  assign rpt_full  = out_valid_o && (out_item_o.status == psq_pkg::ST_FULL);
  assign rpt_empty = out_valid_o && (out_item_o.status == psq_pkg::ST_EMPTY);
  assign at_cap    = out_item_o.count == psq_pkg::CntW'(psq_pkg::Capacity);
  assign out_zero  = out_item_o.out_value == '0;

  // stalled result transaction holds
  `PSQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))

  // waiting input transaction holds
  `PSQ_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(in_item_i))

  // a full report only comes with a full store and no data
  `PSQ_ASSERT_IMPL(a_full_count, clk_i, rst_ni, rpt_full, at_cap && out_zero)

  // an empty report only comes with an empty store and no data
  `PSQ_ASSERT_IMPL(a_empty_count, clk_i, rst_ni, rpt_empty, out_item_o.count == '0 && out_zero)

  // an accepted transaction is followed by a valid result on the output
  `PSQ_ASSERT_IMPL(a_accept_progress, clk_i, rst_ni, $past(in_fire, 2), out_valid_o)

endmodule

bind positional_sequence_store_core psq_checker u_psq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
